/* src/ptte_pkg.sv */
// ----------------------------------------------------------------------------
// ptte_pkg
// Shared widths, register codes and the arctangent table for the pixel to
// two-theta / eta transform.
// ----------------------------------------------------------------------------
package ptte_pkg;

  localparam int MAX_SLOW     = 4096;
  localparam int MAX_FAST     = 4096;
  localparam int CORDIC_STEPS = 16;

  localparam int IDX_W     = 12;
  localparam int CENTER_W  = 20;
  localparam int PITCH_W   = 24;
  localparam int DIST_W    = 32;
  localparam int TILT_W    = 36;
  localparam int COEF_W    = 18;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 36;

  localparam int DIFF_W  = 21;   // index minus centre, Q.8
  localparam int POS_W   = 46;   // detector-plane position, Q.16 um
  localparam int SPLIT_W = 23;   // low part of a position operand
  localparam int PPL_W   = COEF_W + SPLIT_W + 1;
  localparam int PPH_W   = COEF_W + POS_W - SPLIT_W;
  localparam int SUM_W   = 64;
  localparam int PRESCALE = 23;
  localparam int COORD_W = SUM_W - PRESCALE;

  localparam int LANE_W  = 44;
  localparam int ANG_W   = 33;
  localparam int TAG_W   = COORD_W + 1;

  localparam int GAIN_W    = 20;
  localparam logic [GAIN_W-1:0] INV_GAIN = 20'd636750;
  localparam int MAG_LO_W  = 22;
  localparam int MAG_HI_W  = 21;

  localparam int TT_W = 15;
  localparam int AZ_W = 16;

  localparam logic signed [ANG_W-1:0] ANG_HALF_TURN = 33'sd1073741824;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_FAST = 4'd0,
    REG_CENTER_SLOW = 4'd1,
    REG_PITCH_FAST  = 4'd2,
    REG_PITCH_SLOW  = 4'd3,
    REG_DISTANCE    = 4'd4,
    REG_TILT_X      = 4'd5,
    REG_TILT_Y      = 4'd6,
    REG_TILT_Z      = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic valid;
    logic special;
  } cordic_stat_t;

  // atan(2^-i)/pi in Q.30
  function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0:  r = 33'sd268435456;
      1:  r = 33'sd158466703;
      2:  r = 33'sd83729454;
      3:  r = 33'sd42502378;
      4:  r = 33'sd21333666;
      5:  r = 33'sd10677233;
      6:  r = 33'sd5339919;
      7:  r = 33'sd2670123;
      8:  r = 33'sd1335082;
      9:  r = 33'sd667543;
      10: r = 33'sd333772;
      11: r = 33'sd166886;
      12: r = 33'sd83443;
      13: r = 33'sd41722;
      14: r = 33'sd20861;
      15: r = 33'sd10430;
      16: r = 33'sd5215;
      17: r = 33'sd2608;
      18: r = 33'sd1304;
      19: r = 33'sd652;
      20: r = 33'sd326;
      21: r = 33'sd163;
      22: r = 33'sd81;
      23: r = 33'sd41;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* src/ptte_cordic.sv */
// ----------------------------------------------------------------------------
// ptte_cordic
// Pipelined vectoring CORDIC: one register stage per iteration, angle in
// Q.30 fractions of pi, magnitude left unscaled.
// ----------------------------------------------------------------------------
module ptte_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic signed [ptte_pkg::LANE_W-1:0]  in_x,
  input  logic signed [ptte_pkg::LANE_W-1:0]  in_y,
  input  logic [ptte_pkg::TAG_W-1:0]          in_tag,
  output ptte_pkg::cordic_stat_t              out_stat,
  output logic signed [ptte_pkg::ANG_W-1:0]   out_angle,
  output logic signed [ptte_pkg::LANE_W-1:0]  out_mag,
  output logic [ptte_pkg::TAG_W-1:0]          out_tag
);
  import ptte_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic                     v  [0:N];
  logic                     sp [0:N];
  logic signed [LANE_W-1:0] xs [0:N];
  logic signed [LANE_W-1:0] ys [0:N];
  logic signed [ANG_W-1:0]  an [0:N];
  logic [TAG_W-1:0]         tg [0:N];

  // Entry: flag the zero / positive-axis case, fold the left half plane.
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tg[0] <= in_tag;
      sp[0] <= (in_y == '0) && !in_x[LANE_W-1];
      if (in_x[LANE_W-1]) begin
        xs[0] <= -in_x;
        ys[0] <= -in_y;
        an[0] <= in_y[LANE_W-1] ? -ANG_HALF_TURN : ANG_HALF_TURN;
      end else begin
        xs[0] <= in_x;
        ys[0] <= in_y;
        an[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_iter
    localparam logic signed [ANG_W-1:0] ATAN_K = atan_q30(k);
    logic signed [LANE_W-1:0] dx;
    logic signed [LANE_W-1:0] dy;

    assign dx = xs[k] >>> k;
    assign dy = ys[k] >>> k;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (adv) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        tg[k+1] <= tg[k];
        sp[k+1] <= sp[k];
        if (sp[k]) begin
          xs[k+1] <= xs[k];
          ys[k+1] <= ys[k];
          an[k+1] <= an[k];
        end else if (!ys[k][LANE_W-1] && ys[k] != '0) begin
          xs[k+1] <= xs[k] + dy;
          ys[k+1] <= ys[k] - dx;
          an[k+1] <= an[k] + ATAN_K;
        end else begin
          xs[k+1] <= xs[k] - dy;
          ys[k+1] <= ys[k] + dx;
          an[k+1] <= an[k] - ATAN_K;
        end
      end
    end
  end

  assign out_stat.valid   = v[N];
  assign out_stat.special = sp[N];
  assign out_angle        = an[N];
  assign out_tag          = tg[N];
  // clamp a negative final x to zero, except on the bypass path
  assign out_mag = (!sp[N] && xs[N][LANE_W-1]) ? '0 : xs[N];

endmodule

/* src/detector_pixel_to_two_theta_eta.sv */
// ----------------------------------------------------------------------------
// detector_pixel_to_two_theta_eta
// Maps a detector pixel (slow, fast index) to two-theta and eta angles.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel channel: slow_index / fast_index with pixel_valid / pixel_stall.
//   Result channel: two_theta / azimuth with result_valid / result_stall.
//   two_theta is Q0.15, azimuth Q1.15 (x pi); one result per pixel, in order.
//   Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; ready
//   is always high. Write only while no pixel is in flight.
//   Throughput: one pixel per clock while pixel_stall is low. The path to
//   result_valid runs through five coordinate stages (centre offset,
//   pitch multiply, split tilt products, product merge, sum and prescale),
//   two 17-stage CORDIC pipelines and a two-stage gain multiply between
//   them.
//   Reset clears all configuration registers to zero and empties the pipe.
//   When the receiver stalls, the output register holds its transaction
//   and one more result lands in a skid register; the pipeline then freezes
//   and pixel_stall rises until the skid register drains.
// ----------------------------------------------------------------------------
module detector_pixel_to_two_theta_eta (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pixel_valid,
  output logic                               pixel_stall,
  input  logic [ptte_pkg::IDX_W-1:0]         slow_index,
  input  logic [ptte_pkg::IDX_W-1:0]         fast_index,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [ptte_pkg::TT_W-1:0]          two_theta,
  output logic signed [ptte_pkg::AZ_W-1:0]   azimuth,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ptte_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptte_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import ptte_pkg::*;

  // configuration registers
  logic [CENTER_W-1:0] center_fast, center_slow;
  logic [PITCH_W-1:0]  pitch_fast, pitch_slow;
  logic [DIST_W-1:0]   sample_distance;
  logic [TILT_W-1:0]   tilt_row_x, tilt_row_y, tilt_row_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_fast     <= '0;
      center_slow     <= '0;
      pitch_fast      <= '0;
      pitch_slow      <= '0;
      sample_distance <= '0;
      tilt_row_x      <= '0;
      tilt_row_y      <= '0;
      tilt_row_z      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_CENTER_FAST: center_fast     <= cfg_data[CENTER_W-1:0];
        REG_CENTER_SLOW: center_slow     <= cfg_data[CENTER_W-1:0];
        REG_PITCH_FAST:  pitch_fast      <= cfg_data[PITCH_W-1:0];
        REG_PITCH_SLOW:  pitch_slow      <= cfg_data[PITCH_W-1:0];
        REG_DISTANCE:    sample_distance <= cfg_data[DIST_W-1:0];
        REG_TILT_X:      tilt_row_x      <= cfg_data[TILT_W-1:0];
        REG_TILT_Y:      tilt_row_y      <= cfg_data[TILT_W-1:0];
        REG_TILT_Z:      tilt_row_z      <= cfg_data[TILT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance and output buffering
  logic adv;
  logic skid_v;
  assign adv         = !skid_v;
  assign pixel_stall = skid_v;

  // stage 1: centre offset
  logic                     v1, oob1;
  logic signed [DIFF_W-1:0] ds1, df1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oob1 <= ({1'b0, slow_index} >= (IDX_W+1)'(MAX_SLOW)) ||
              ({1'b0, fast_index} >= (IDX_W+1)'(MAX_FAST));
      ds1  <= DIFF_W'({1'b0, slow_index, 8'b0}) - DIFF_W'({1'b0, center_slow});
      df1  <= DIFF_W'({1'b0, fast_index, 8'b0}) - DIFF_W'({1'b0, center_fast});
    end
  end

  // stage 2: scale by pixel pitch
  logic                    v2, oob2;
  logic signed [POS_W-1:0] s2, f2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oob2 <= oob1;
      s2   <= ds1 * $signed({1'b0, pitch_slow});
      f2   <= df1 * $signed({1'b0, pitch_fast});
    end
  end

  // stage 3: tilt products, each split into low and high partial products
  // slots: 0 R1*f, 1 R2*s, 2 R4*f, 3 R5*s, 4 R7*f, 5 R8*s
  logic signed [COEF_W-1:0] coef [0:5];
  logic signed [POS_W-1:0]  opnd [0:5];

  always_comb begin
    coef[0] = tilt_row_x[COEF_W-1:0];
    coef[1] = tilt_row_x[TILT_W-1:COEF_W];
    coef[2] = tilt_row_y[COEF_W-1:0];
    coef[3] = tilt_row_y[TILT_W-1:COEF_W];
    coef[4] = tilt_row_z[COEF_W-1:0];
    coef[5] = tilt_row_z[TILT_W-1:COEF_W];
    for (int i = 0; i < 6; i++) begin
      opnd[i] = (i % 2 == 0) ? f2 : s2;
    end
  end

  logic                    v3, oob3;
  logic [DIST_W-1:0]       dist3;
  logic signed [PPL_W-1:0] pl3 [0:5];
  logic signed [PPH_W-1:0] ph3 [0:5];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oob3  <= oob2;
      dist3 <= sample_distance;
      for (int i = 0; i < 6; i++) begin
        pl3[i] <= coef[i] * $signed({1'b0, opnd[i][SPLIT_W-1:0]});
        ph3[i] <= coef[i] * $signed(opnd[i][POS_W-1:SPLIT_W]);
      end
    end
  end

  // stage 4: merge partial products
  logic                    v4, oob4;
  logic [DIST_W-1:0]       dist4;
  logic signed [SUM_W-1:0] pp4 [0:5];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oob4  <= oob3;
      dist4 <= dist3;
      for (int i = 0; i < 6; i++) begin
        pp4[i] <= $signed({ph3[i], {SPLIT_W{1'b0}}}) + SUM_W'(pl3[i]);
      end
    end
  end

  // stage 5: lab coordinates, prescaled to Q.9
  logic                      v5, oob5;
  logic signed [SUM_W-1:0]   x_sum, y_sum, z_sum;
  logic signed [COORD_W-1:0] x5, y5, z5;

  assign x_sum = pp4[0] + pp4[1] + $signed({8'b0, dist4, 24'b0});
  assign y_sum = pp4[2] + pp4[3];
  assign z_sum = pp4[4] + pp4[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oob5 <= oob4;
      x5   <= x_sum[SUM_W-1:PRESCALE];
      y5   <= y_sum[SUM_W-1:PRESCALE];
      z5   <= z_sum[SUM_W-1:PRESCALE];
    end
  end

  // eta CORDIC on (y, z); x and the frame flag ride in the tag
  cordic_stat_t              c1_stat;
  logic signed [ANG_W-1:0]   c1_angle;
  logic signed [LANE_W-1:0]  c1_mag;
  logic [TAG_W-1:0]          c1_tag;

  ptte_cordic u_cordic_eta (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v5),
    .in_x      (LANE_W'(y5)),
    .in_y      (LANE_W'(z5)),
    .in_tag    ({oob5, x5}),
    .out_stat  (c1_stat),
    .out_angle (c1_angle),
    .out_mag   (c1_mag),
    .out_tag   (c1_tag)
  );

  // gain correction: magnitude * INV_GAIN >> 20, in two halves; special results bypass it
  logic                           vm1, spm1;
  logic signed [LANE_W-1:0]       magm1;
  logic [MAG_LO_W+GAIN_W-1:0]     mlo1;
  logic [MAG_HI_W+GAIN_W-1:0]     mhi1;
  logic signed [ANG_W-1:0]        etam1;
  logic [TAG_W-1:0]               tagm1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm1 <= 1'b0;
    end else if (adv) begin
      vm1 <= c1_stat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      spm1  <= c1_stat.special;
      magm1 <= c1_mag;
      mlo1  <= c1_mag[MAG_LO_W-1:0] * INV_GAIN;
      mhi1  <= c1_mag[MAG_LO_W+MAG_HI_W-1:MAG_LO_W] * INV_GAIN;
      etam1 <= c1_angle;
      tagm1 <= c1_tag;
    end
  end

  localparam int MPROD_W = MAG_LO_W + MAG_HI_W + GAIN_W;

  logic                      vm2;
  logic signed [LANE_W-1:0]  radm2;
  logic signed [ANG_W-1:0]   etam2;
  logic [TAG_W-1:0]          tagm2;
  logic [MPROD_W-1:0]        mprod;

  assign mprod = {mhi1, {MAG_LO_W{1'b0}}} + MPROD_W'(mlo1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vm2 <= 1'b0;
    end else if (adv) begin
      vm2 <= vm1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      radm2 <= spm1 ? magm1 : LANE_W'(mprod[MPROD_W-1:GAIN_W]);
      etam2 <= etam1;
      tagm2 <= tagm1;
    end
  end

  // two-theta CORDIC on (x, radial); eta and the frame flag ride in the tag
  cordic_stat_t              c2_stat;
  logic signed [ANG_W-1:0]   c2_angle;
  logic [TAG_W-1:0]          c2_tag;
  logic [TAG_W-1:0]          c2_tag_in;

  assign c2_tag_in = {tagm2[TAG_W-1], (COORD_W-ANG_W)'(0), etam2};

  ptte_cordic u_cordic_tth (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (vm2),
    .in_x      (LANE_W'($signed(tagm2[COORD_W-1:0]))),
    .in_y      (radm2),
    .in_tag    (c2_tag_in),
    .out_stat  (c2_stat),
    .out_angle (c2_angle),
    .out_mag   (),
    .out_tag   (c2_tag)
  );

  // round to Q.15 (two-theta Q0.15, azimuth Q1.15) and saturate
  localparam int Q_W = ANG_W - 15;

  logic signed [ANG_W-1:0] tth_r, eta_r;
  logic signed [Q_W-1:0]   tth_q, eta_q;
  logic [TT_W-1:0]         fin_tt;
  logic signed [AZ_W-1:0]  fin_az;
  logic                    fin_oob;

  assign fin_oob = c2_tag[TAG_W-1];
  assign tth_r   = c2_angle + ANG_W'(16384);
  assign eta_r   = $signed(c2_tag[ANG_W-1:0]) + ANG_W'(16384);
  assign tth_q   = tth_r[ANG_W-1:15];
  assign eta_q   = eta_r[ANG_W-1:15];

  always_comb begin
    if (fin_oob || tth_q[Q_W-1]) begin
      fin_tt = '0;
    end else if (tth_q > Q_W'(32767)) begin
      fin_tt = 15'h7fff;
    end else begin
      fin_tt = tth_q[TT_W-1:0];
    end
    if (fin_oob) begin
      fin_az = '0;
    end else if (eta_q > $signed(Q_W'(32767))) begin
      fin_az = 16'sh7fff;
    end else if (eta_q < -$signed(Q_W'(32768))) begin
      fin_az = 16'sh8000;
    end else begin
      fin_az = eta_q[AZ_W-1:0];
    end
  end

  // output register plus skid
  logic [TT_W-1:0]        skid_tt;
  logic signed [AZ_W-1:0] skid_az;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_v       <= 1'b0;
    end else if (skid_v) begin
      if (!result_stall) begin
        result_valid <= 1'b1;
        skid_v       <= 1'b0;
      end
    end else if (!result_valid || !result_stall) begin
      result_valid <= c2_stat.valid;
    end else if (c2_stat.valid) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (!result_stall) begin
        two_theta <= skid_tt;
        azimuth   <= skid_az;
      end
    end else if (!result_valid || !result_stall) begin
      two_theta <= fin_tt;
      azimuth   <= fin_az;
    end else begin
      // hold the stalled transaction, park the next one
      skid_tt <= fin_tt;
      skid_az <= fin_az;
    end
  end

endmodule

/* src/ptte_checker.sv */
// ----------------------------------------------------------------------------
// ptte_checker
// Port-level checks on the pixel to two-theta / eta transform.
// ----------------------------------------------------------------------------
module ptte_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               pixel_valid,
  input logic                               pixel_stall,
  input logic [ptte_pkg::IDX_W-1:0]         slow_index,
  input logic [ptte_pkg::IDX_W-1:0]         fast_index,
  input logic                               result_valid,
  input logic                               result_stall,
  input logic [ptte_pkg::TT_W-1:0]          two_theta,
  input logic signed [ptte_pkg::AZ_W-1:0]   azimuth,
  input logic                               cfg_valid,
  input logic                               cfg_ready,
  input logic [ptte_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [ptte_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import ptte_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid &&
      $stable(two_theta) && $stable(azimuth))
    else $error("stalled result transaction changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !pixel_stall)
    else $error("result or stall present after reset");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> result_valid)
    else $error("pixel channel stalled with no pending result");

  a_stall_drains: assert property (@(posedge clk) disable iff (rst)
    pixel_stall && !result_stall |=> !pixel_stall && result_valid)
    else $error("skid did not drain into the output register");

endmodule

bind detector_pixel_to_two_theta_eta ptte_checker u_ptte_checker (.*);
